// File: hw/rtl/rlbc_pkg.sv
// shared types and codes for the buffer cache
package rlbc_pkg;

	typedef enum logic [2:0] {
		ST_HIT       = 3'd0,
		ST_MISS      = 3'd1,
		ST_EXHAUSTED = 3'd2,
		ST_RELEASED  = 3'd3,
		ST_BAD_REL   = 3'd4,
		ST_OVERFLOW  = 3'd5
	} status_t;

	localparam logic CMD_ACQUIRE = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	typedef struct packed {
		logic        command;
		logic [31:0] file_id;
		logic [31:0] block_index;
		logic [5:0]  slot;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  slot_out;
		logic [15:0] count_after;
		logic        evicted;
	} out_word_t;

	// controller to datapath
	typedef struct packed {
		logic load;     // capture input word
		logic search;   // step the tag search one slot
		logic fetch;    // read count and links of the target slot
		logic execute;  // apply the update and form the result
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic search_done;
	} dp_stat_t;

endpackage

// File: hw/rtl/rlbc_datapath.sv
// tag store, counts, idle list and the result register
module rlbc_datapath #(
	parameter int SLOTS      = 64,
	parameter int COUNT_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rlbc_pkg::in_word_t   in_word,
	input  rlbc_pkg::dp_cmd_t    cmd,
	output rlbc_pkg::dp_stat_t   stat,
	output rlbc_pkg::out_word_t  result
);
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [COUNT_BITS-1:0] CMAX = '1;

	// memories: one read and one write address a cycle, reads registered
	logic [31:0]           tag_file_q  [SLOTS];
	logic [31:0]           tag_block_q [SLOTS];
	logic [COUNT_BITS-1:0] cnt_q       [SLOTS];
	logic [SW-1:0]         nxt_q       [SLOTS];
	logic [SW-1:0]         prv_q       [SLOTS];

	logic [SLOTS-1:0]    valid_q;
	logic [SW-1:0]       head_q, tail_q;
	logic [CW-1:0]       idle_cnt_q, unused_q;

	rlbc_pkg::in_word_t  req_q;
	rlbc_pkg::out_word_t res_q;

	logic [SW-1:0]       scan_q;
	logic                issued_all_q, hit_q, scan_end_q;
	logic [SW-1:0]       hit_slot_q;
	logic                look_s1, vld_s1;
	logic [31:0]         tf_s1, tb_s1;
	logic [SW-1:0]       idx_s1;
	logic                scan_issue, match_s1, last_s1;

	logic [SW-1:0]         tgt, tgt_q;
	logic [COUNT_BITS-1:0] cnt_rd_q, cur_cnt;
	logic [SW-1:0]         nxt_rd_q, prv_rd_q;
	logic                  vld_rd_q;

	logic [SW-1:0] rs;
	logic          rs_ok, is_rel, rel_ok, cnt_full;

	// release slot in range
	assign rs     = SW'(req_q.slot);
	assign rs_ok  = (32'(req_q.slot) < SLOTS);
	assign is_rel = (req_q.command == rlbc_pkg::CMD_RELEASE);

	// search reads one slot per cycle and compares it the cycle after
	assign scan_issue = cmd.search && !is_rel && !hit_q && !scan_end_q && !issued_all_q;
	assign match_s1   = vld_s1 && tf_s1 == req_q.file_id && tb_s1 == req_q.block_index;
	assign last_s1    = (idx_s1 == SW'(SLOTS - 1));
	assign stat.search_done = is_rel || hit_q || scan_end_q;

	// never-used slots have no written count and read as zero
	assign cur_cnt  = vld_rd_q ? cnt_rd_q : '0;
	assign rel_ok   = rs_ok && vld_rd_q && (cnt_rd_q != '0);
	assign cnt_full = (cur_cnt == CMAX);

	always_comb begin
		if (is_rel) tgt = rs;
		else if (hit_q) tgt = hit_slot_q;
		else if (unused_q != '0) tgt = SW'(unused_q - 1'b1);
		else tgt = tail_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q       <= '0;
			issued_all_q <= 1'b0;
			look_s1      <= 1'b0;
			hit_q        <= 1'b0;
			scan_end_q   <= 1'b0;
		end else if (cmd.load) begin
			scan_q       <= '0;
			issued_all_q <= 1'b0;
			look_s1      <= 1'b0;
			hit_q        <= 1'b0;
			scan_end_q   <= 1'b0;
		end else begin
			look_s1 <= scan_issue;
			if (scan_issue) begin
				if (scan_q == SW'(SLOTS - 1)) issued_all_q <= 1'b1;
				else scan_q <= scan_q + 1'b1;
			end
			if (look_s1 && !hit_q && !scan_end_q) begin
				if (match_s1) hit_q <= 1'b1;
				else if (last_s1) scan_end_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			idle_cnt_q <= '0;
			unused_q   <= CW'(SLOTS);
		end else if (cmd.execute) begin
			if (is_rel) begin
				if (rel_ok && cnt_rd_q == COUNT_BITS'(1)) begin
					if (idle_cnt_q == '0) tail_q <= tgt_q;
					head_q     <= tgt_q;
					idle_cnt_q <= idle_cnt_q + 1'b1;
				end
			end else if (hit_q) begin
				if (cur_cnt == '0) begin
					if (tgt_q == head_q) head_q <= nxt_rd_q;
					if (tgt_q == tail_q) tail_q <= prv_rd_q;
					idle_cnt_q <= idle_cnt_q - 1'b1;
				end
			end else if (unused_q != '0) begin
				unused_q       <= unused_q - 1'b1;
				valid_q[tgt_q] <= 1'b1;
			end else if (idle_cnt_q != '0) begin
				// evict least recently released (tail)
				if (tgt_q == head_q) head_q <= nxt_rd_q;
				tail_q     <= prv_rd_q;
				idle_cnt_q <= idle_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= in_word;
		if (scan_issue) begin
			tf_s1  <= tag_file_q[scan_q];
			tb_s1  <= tag_block_q[scan_q];
			vld_s1 <= valid_q[scan_q];
			idx_s1 <= scan_q;
		end
		if (look_s1 && !hit_q && !scan_end_q && match_s1) hit_slot_q <= idx_s1;
		if (cmd.fetch) begin
			tgt_q    <= tgt;
			cnt_rd_q <= cnt_q[tgt];
			nxt_rd_q <= nxt_q[tgt];
			prv_rd_q <= prv_q[tgt];
			vld_rd_q <= valid_q[tgt];
		end
		if (cmd.execute) begin
			if (is_rel) begin
				if (rel_ok) begin
					cnt_q[tgt_q] <= cnt_rd_q - 1'b1;
					if (cnt_rd_q == COUNT_BITS'(1) && idle_cnt_q != '0) begin
						prv_q[head_q] <= tgt_q;
						nxt_q[tgt_q]  <= head_q;
					end
				end
			end else if (hit_q) begin
				if (!cnt_full) begin
					cnt_q[tgt_q] <= cur_cnt + 1'b1;
					if (cur_cnt == '0) begin
						if (tgt_q != head_q) nxt_q[prv_rd_q] <= nxt_rd_q;
						if (tgt_q != tail_q) prv_q[nxt_rd_q] <= prv_rd_q;
					end
				end
			end else if (unused_q != '0 || idle_cnt_q != '0) begin
				tag_file_q[tgt_q]  <= req_q.file_id;
				tag_block_q[tgt_q] <= req_q.block_index;
				cnt_q[tgt_q]       <= COUNT_BITS'(1);
				if (unused_q == '0 && tgt_q != head_q) nxt_q[prv_rd_q] <= nxt_rd_q;
			end
		end
	end

	// result formed from the fetched pre-update state
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			res_q.evicted <= 1'b0;
			if (is_rel) begin
				res_q.slot_out <= req_q.slot;
				if (!rs_ok) begin
					res_q.status      <= rlbc_pkg::ST_BAD_REL;
					res_q.count_after <= '0;
				end else if (!rel_ok) begin
					res_q.status      <= rlbc_pkg::ST_BAD_REL;
					res_q.count_after <= 16'(cur_cnt);
				end else begin
					res_q.status      <= rlbc_pkg::ST_RELEASED;
					res_q.count_after <= 16'(cnt_rd_q - 1'b1);
				end
			end else if (hit_q) begin
				res_q.slot_out <= 6'(tgt_q);
				if (cnt_full) begin
					res_q.status      <= rlbc_pkg::ST_OVERFLOW;
					res_q.count_after <= 16'(cur_cnt);
				end else begin
					res_q.status      <= rlbc_pkg::ST_HIT;
					res_q.count_after <= 16'(cur_cnt + 1'b1);
				end
			end else if (unused_q != '0) begin
				res_q.status      <= rlbc_pkg::ST_MISS;
				res_q.slot_out    <= 6'(tgt_q);
				res_q.count_after <= 16'd1;
			end else if (idle_cnt_q != '0) begin
				res_q.status      <= rlbc_pkg::ST_MISS;
				res_q.slot_out    <= 6'(tgt_q);
				res_q.count_after <= 16'd1;
				res_q.evicted     <= 1'b1;
			end else begin
				res_q.status      <= rlbc_pkg::ST_EXHAUSTED;
				res_q.slot_out    <= '0;
				res_q.count_after <= '0;
			end
		end
	end

	assign result = res_q;

endmodule

// File: hw/rtl/rlbc_ctrl.sv
// request sequencer: load, search, fetch, execute, present result
module rlbc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  rlbc_pkg::dp_stat_t  stat,
	output rlbc_pkg::dp_cmd_t   cmd
);
	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SEARCH = 5'b00010,
		S_FETCH  = 5'b00100,
		S_EXEC   = 5'b01000,
		S_OUT    = 5'b10000
	} state_t;

	state_t state_q;
	logic   in_fire;

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = (state_q == S_OUT);
	assign in_fire     = in_valid && in_ready;
	assign cmd.load    = in_fire;
	assign cmd.search  = (state_q == S_SEARCH);
	assign cmd.fetch   = (state_q == S_FETCH);
	assign cmd.execute = (state_q == S_EXEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:   if (in_fire) state_q <= S_SEARCH;
				S_SEARCH: if (stat.search_done) state_q <= S_FETCH;
				S_FETCH:  state_q <= S_EXEC;
				S_EXEC:   state_q <= S_OUT;
				S_OUT:    if (out_ready) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: hw/rtl/refcounted_lru_buffer_cache_top.sv
// top level of the reference-counted lru buffer cache
//  channel | direction | handshake              | word
//  in      | input     | in_valid / in_ready    | rlbc_pkg::in_word_t
//  out     | output    | out_valid / out_ready  | rlbc_pkg::out_word_t
// from one accepted word to the next: a release skips the tag search; an acquire
// runs it until a hit or, on a miss, through all SLOTS slots; the search reads
// one slot per cycle and compares it the cycle after, then fetch and update.
// one word in flight; in_ready is low until the result is taken, however long
// out_ready stays low.
// reset clears valid bits and list registers; counts of unused slots read as 0.
module refcounted_lru_buffer_cache_top #(
	parameter int SLOTS      = 64,
	parameter int COUNT_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rlbc_pkg::in_word_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output rlbc_pkg::out_word_t  out_data
);
	rlbc_pkg::dp_cmd_t  cmd;
	rlbc_pkg::dp_stat_t stat;

	rlbc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
	);

	rlbc_datapath #(.SLOTS(SLOTS), .COUNT_BITS(COUNT_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_word(in_data), .cmd(cmd),
		.stat(stat), .result(out_data)
	);

endmodule
